// ----- hw/rtl/pfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// Request/result structs, command and status codes, frame table geometry.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int unsigned NUM_FRAMES = 32;
  localparam int unsigned MAX_PROCS  = 16;
  localparam int unsigned MAX_PAGES  = 64;

  localparam int unsigned FRAME_W = $clog2(NUM_FRAMES);
  localparam int unsigned OWNER_W = 5;
  localparam int unsigned PAGE_W  = 6;

  localparam logic [1:0] CMD_FAULT = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] ST_FREE     = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] proc_id;
    logic [6:0] page_num;
  } pfa_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] frame_index;
    logic [4:0] victim_proc;
    logic [5:0] evicted_page;
  } pfa_rsp_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [PAGE_W-1:0]  page;
  } pfa_entry_t;

  typedef struct packed {
    logic               we;
    logic [FRAME_W-1:0] waddr;
    pfa_entry_t         wdata;
    logic               re;
    logic [FRAME_W-1:0] raddr;
  } pfa_ram_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DONE
  } pfa_state_t;

endpackage

// ----- hw/rtl/pfa_frame_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_frame_ram: frame table storage
// One write port, one registered read port; holds owner and page per frame.
// ----------------------------------------------------------------------------
module pfa_frame_ram (
  input  logic                  clk,
  input  pfa_pkg::pfa_ram_req_t req,
  output pfa_pkg::pfa_entry_t   rd_data
);
  import pfa_pkg::*;

  pfa_entry_t mem [NUM_FRAMES];
  pfa_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/pfa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_ctrl: allocator sequencer
// Checks the request, scans the occupancy bits one frame per cycle, drives
// the frame table and holds the result register.
// ----------------------------------------------------------------------------
module pfa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pfa_pkg::pfa_req_t     in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pfa_pkg::pfa_rsp_t     out_data,
  output pfa_pkg::pfa_ram_req_t ram_req,
  input  pfa_pkg::pfa_entry_t   ram_rd_data
);
  import pfa_pkg::*;

  localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(NUM_FRAMES - 1);

  pfa_state_t         state_r, state_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [4:0]         pid_r, pid_nxt;
  logic [6:0]         page_r, page_nxt;
  logic [FRAME_W-1:0] cnt_r, cnt_nxt;
  logic [FRAME_W-1:0] ptr_r, ptr_nxt;
  logic [NUM_FRAMES-1:0] mask_r, mask_nxt;
  pfa_rsp_t           res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  pfa_rsp_t           out_data_r, out_data_nxt;

  logic in_ok;
  logic cnt_free;
  logic cnt_last;
  logic out_free;
  logic [OWNER_W-1:0] owner_w;

  always_comb begin
    in_ok = 1'b0;
    case (in_data.command)
      CMD_FAULT: in_ok = (in_data.proc_id != 5'd0) && (32'(in_data.proc_id) <= MAX_PROCS) &&
                         (32'(in_data.page_num) < MAX_PAGES);
      CMD_ALLOC: in_ok = (32'(in_data.proc_id) < MAX_PROCS) &&
                         (32'(in_data.page_num) < MAX_PAGES);
      default:   in_ok = 1'b0;
    endcase
  end

  assign cnt_free = !mask_r[cnt_r];
  assign cnt_last = (cnt_r == LAST_FRAME);
  assign out_free = !out_valid_r || !out_stall;
  assign owner_w  = (cmd_r == CMD_FAULT) ? pid_r : OWNER_W'(pid_r + 5'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.command == CMD_CLEAR || !in_ok) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_free) begin
          state_nxt = S_DONE;
        end else if (cnt_last) begin
          state_nxt = (cmd_r == CMD_FAULT) ? S_READ : S_DONE;
        end
      end
      S_READ: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = (state_r != S_IDLE);
    ram_req.we    = 1'b0;
    ram_req.waddr = cnt_r;
    ram_req.wdata = '{owner: owner_w, page: page_r[PAGE_W-1:0]};
    ram_req.re    = 1'b0;
    ram_req.raddr = ptr_r;
    case (state_r)
      S_SCAN: begin
        ram_req.we = cnt_free;
        ram_req.re = !cnt_free && cnt_last;
      end
      S_READ: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ptr_r;
      end
      default: begin
        ram_req.we = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    cmd_nxt       = cmd_r;
    pid_nxt       = pid_r;
    page_nxt      = page_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    mask_nxt      = mask_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = in_data.command;
          pid_nxt  = in_data.proc_id;
          page_nxt = in_data.page_num;
          cnt_nxt  = '0;
          res_nxt  = '0;
          if (in_data.command == CMD_CLEAR) begin
            mask_nxt       = '0;
            ptr_nxt        = '0;
            res_nxt.status = ST_CLEARED;
          end else if (!in_ok) begin
            res_nxt.status = ST_INVALID;
          end
        end
      end
      S_SCAN: begin
        if (cnt_free) begin
          mask_nxt[cnt_r]     = 1'b1;
          res_nxt.status      = ST_FREE;
          res_nxt.frame_index = 5'(cnt_r);
        end else if (cnt_last) begin
          res_nxt.status = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_READ: begin
        ptr_nxt              = (ptr_r == LAST_FRAME) ? '0 : ptr_r + 1'b1;
        res_nxt.status       = ST_REPLACED;
        res_nxt.frame_index  = 5'(ptr_r);
        res_nxt.victim_proc  = 5'(ram_rd_data.owner);
        res_nxt.evicted_page = 6'(ram_rd_data.page);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pid_r      <= pid_nxt;
    page_r     <= page_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/page_frame_allocator_fifo_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator_fifo_unit: frame allocator with round-robin eviction
// Request channel in_valid/in_stall/in_data: fault, allocate-only or clear.
// Result channel out_valid/out_stall/out_data: one result per request.
// A request is taken only while the sequencer is idle; in_stall is high
// while one is in progress. A clear or a rejected request skips the scan.
// Fault and allocate scan the occupancy bits one frame per cycle, lowest
// first; on a full table a fault also reads the victim from the frame table
// RAM at the replacement pointer and writes the new owner.
// The result register lets the next request enter while a result waits;
// if out_stall holds, the sequencer waits in its final step until the
// result register frees. Reset empties the occupancy bits, zeroes the
// pointer and drops any pending result; table contents are not cleared.
// ----------------------------------------------------------------------------
module page_frame_allocator_fifo_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfa_pkg::pfa_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pfa_pkg::pfa_rsp_t out_data
);
  import pfa_pkg::*;

  pfa_ram_req_t ram_req;
  pfa_entry_t   ram_rd_data;

  pfa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  pfa_frame_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while busy");

  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_REPLACED) |->
      (out_data.victim_proc == 5'd0 && out_data.evicted_page == 6'd0))
    else $error("victim reported without replacement");

  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_INVALID || out_data.status == ST_FULL ||
                   out_data.status == ST_CLEARED)) |-> (out_data.frame_index == 5'd0))
    else $error("frame reported for failed request");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= ST_CLEARED))
    else $error("bad status code");

endmodule

// ----- tb/sv/page_frame_allocator_fifo_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator_fifo_unit_test: self-checking bench for the allocator
// Walks a short stimulus table (reset state, invalid fields, unused command,
// clears, filling the table, full allocate, replacement with pointer wrap),
// then drives random fault/allocate/clear traffic with random gaps and
// result stalls. Each result is checked against a cycle-free frame table
// model kept here, or against a typed-in value where one is given.
// ----------------------------------------------------------------------------
module page_frame_allocator_fifo_unit_test;
  import pfa_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         IDLE_LIMIT  = 2000;
  localparam int         RAND_ITEMS  = 370;

  typedef struct {
    bit       known;
    pfa_rsp_t rsp;
  } known_rsp_t;

  typedef struct {
    pfa_req_t   req;
    int         count;
    known_rsp_t want;
  } stim_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pfa_req_t in_data;
  logic     out_valid;
  logic     out_stall;
  pfa_rsp_t out_data;

  // frame table model
  logic [NUM_FRAMES-1:0] frame_busy = '0;
  logic [OWNER_W-1:0]    frame_owner [NUM_FRAMES];
  logic [PAGE_W-1:0]     frame_page  [NUM_FRAMES];
  logic [FRAME_W-1:0]    evict_ptr = '0;

  known_rsp_t  typed_responses[$];
  pfa_rsp_t    pending_responses[$];
  stim_row_t   stim_rows[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;

  page_frame_allocator_fifo_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic pfa_rsp_t frame_table_response(input pfa_req_t req);
    pfa_rsp_t rsp;
    int       free_idx;
    rsp = '0;
    rsp.status = ST_INVALID;
    free_idx = -1;
    for (int f = NUM_FRAMES - 1; f >= 0; f--) begin
      if (!frame_busy[f]) free_idx = f;
    end
    case (req.command)
      CMD_FAULT: begin
        if (req.proc_id >= 1 && req.proc_id <= MAX_PROCS && req.page_num < MAX_PAGES) begin
          if (free_idx >= 0) begin
            rsp.status = ST_FREE;
            rsp.frame_index = free_idx[FRAME_W-1:0];
          end else begin
            rsp.status = ST_REPLACED;
            rsp.frame_index = evict_ptr;
            rsp.victim_proc = frame_owner[evict_ptr];
            rsp.evicted_page = frame_page[evict_ptr];
            evict_ptr = evict_ptr + 1'b1;  // wraps at NUM_FRAMES (power of two)
          end
          frame_busy[rsp.frame_index] = 1'b1;
          frame_owner[rsp.frame_index] = req.proc_id;
          frame_page[rsp.frame_index] = req.page_num[PAGE_W-1:0];
        end
      end
      CMD_ALLOC: begin
        if (req.proc_id < MAX_PROCS && req.page_num < MAX_PAGES) begin
          if (free_idx >= 0) begin
            rsp.status = ST_FREE;
            rsp.frame_index = free_idx[FRAME_W-1:0];
            frame_busy[rsp.frame_index] = 1'b1;
            frame_owner[rsp.frame_index] = req.proc_id + 5'd1;
            frame_page[rsp.frame_index] = req.page_num[PAGE_W-1:0];
          end else begin
            rsp.status = ST_FULL;
          end
        end
      end
      CMD_CLEAR: begin
        frame_busy = '0;
        evict_ptr = '0;
        rsp.status = ST_CLEARED;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [4:0] pid, input logic [6:0] page,
                         input int count, input bit known, input logic [2:0] status,
                         input logic [4:0] frame);
    stim_row_t row;
    row.req = '{command: cmd, proc_id: pid, page_num: page};
    row.count = count;
    row.want.known = known;
    row.want.rsp = '{status: status, frame_index: frame, victim_proc: '0, evicted_page: '0};
    stim_rows.push_back(row);
  endtask

  task automatic send_request(input pfa_req_t req, input known_rsp_t want);
    int gap;
    if ($urandom_range(0, 29) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_responses.push_back(want);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: random stall before each result
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) out_quiet = !out_quiet;
      hold = out_quiet ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : monitor
    known_rsp_t typed;
    pfa_rsp_t   predicted;
    pfa_rsp_t   want;
    bit         took_req;
    bit         took_rsp;
    took_req = rst_n && in_valid && !in_stall;
    took_rsp = rst_n && out_valid && !out_stall;
    if (took_rsp) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_data);
        mismatches++;
      end else begin
        want = pending_responses.pop_front();
        if (want.status !== out_data.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_data.status);
          mismatches++;
        end
        if (want.frame_index !== out_data.frame_index) begin
          $display("%0t: frame_index expected %0d, got %0d", $time, want.frame_index,
                   out_data.frame_index);
          mismatches++;
        end
        if (want.victim_proc !== out_data.victim_proc) begin
          $display("%0t: victim_proc expected %0d, got %0d", $time, want.victim_proc,
                   out_data.victim_proc);
          mismatches++;
        end
        if (want.evicted_page !== out_data.evicted_page) begin
          $display("%0t: evicted_page expected %0d, got %0d", $time, want.evicted_page,
                   out_data.evicted_page);
          mismatches++;
        end
      end
    end
    if (took_req) begin
      typed = typed_responses.pop_front();
      predicted = frame_table_response(in_data);
      pending_responses.push_back(typed.known ? typed.rsp : predicted);
    end
    if (took_req || took_rsp) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    pfa_req_t   req;
    known_rsp_t none;
    int         pick;
    none = '{known: 1'b0, rsp: '0};
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;

    // empty table after reset
    add_row(CMD_ALLOC,  5'd0,  7'd0,   1,  1'b1, ST_FREE,     5'd0);
    // out-of-range fields and the unused command
    add_row(CMD_FAULT,  5'd0,  7'd5,   1,  1'b1, ST_INVALID,  5'd0);
    add_row(CMD_FAULT,  5'd17, 7'd5,   1,  1'b1, ST_INVALID,  5'd0);
    add_row(CMD_FAULT,  5'd31, 7'd127, 1,  1'b1, ST_INVALID,  5'd0);
    add_row(CMD_FAULT,  5'd16, 7'd64,  1,  1'b1, ST_INVALID,  5'd0);
    add_row(CMD_ALLOC,  5'd16, 7'd0,   1,  1'b1, ST_INVALID,  5'd0);
    add_row(CMD_ALLOC,  5'd31, 7'd127, 1,  1'b1, ST_INVALID,  5'd0);
    add_row(CMD_ALLOC,  5'd15, 7'd64,  1,  1'b1, ST_INVALID,  5'd0);
    add_row(CMD_UNUSED, 5'd31, 7'd127, 1,  1'b1, ST_INVALID,  5'd0);
    add_row(CMD_UNUSED, 5'd0,  7'd0,   1,  1'b1, ST_INVALID,  5'd0);
    // largest legal fields
    add_row(CMD_FAULT,  5'd16, 7'd63,  1,  1'b1, ST_FREE,     5'd1);
    add_row(CMD_ALLOC,  5'd15, 7'd63,  1,  1'b1, ST_FREE,     5'd2);
    add_row(CMD_CLEAR,  5'd0,  7'd0,   1,  1'b1, ST_CLEARED,  5'd0);
    add_row(CMD_CLEAR,  5'd31, 7'd127, 1,  1'b1, ST_CLEARED,  5'd0);
    // fill the table, then full allocate and replacement through a pointer wrap
    add_row(CMD_FAULT,  5'd1,  7'd0,   1,  1'b1, ST_FREE,     5'd0);
    add_row(CMD_ALLOC,  5'd7,  7'd42,  30, 1'b0, ST_FREE,     5'd0);
    add_row(CMD_FAULT,  5'd9,  7'd21,  1,  1'b1, ST_FREE,     5'd31);
    add_row(CMD_ALLOC,  5'd0,  7'd0,   1,  1'b1, ST_FULL,     5'd0);
    add_row(CMD_FAULT,  5'd16, 7'd63,  1,  1'b0, ST_REPLACED, 5'd0);
    add_row(CMD_FAULT,  5'd5,  7'd33,  31, 1'b0, ST_REPLACED, 5'd0);
    add_row(CMD_FAULT,  5'd2,  7'd1,   1,  1'b0, ST_REPLACED, 5'd0);
    add_row(CMD_CLEAR,  5'd0,  7'd0,   1,  1'b1, ST_CLEARED,  5'd0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      repeat (stim_rows[i].count) send_request(stim_rows[i].req, stim_rows[i].want);
    end

    // mostly legal faults so the table fills and replacement wraps; clears are rare
    repeat (RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      req.proc_id  = 5'($urandom_range(0, 31));
      req.page_num = 7'($urandom_range(0, 127));
      if (pick < 1) begin
        req.command = CMD_CLEAR;
      end else if (pick < 4) begin
        req.command = CMD_UNUSED;
      end else if (pick < 12) begin
        req.command = $urandom_range(0, 1) ? CMD_FAULT : CMD_ALLOC;
        if ($urandom_range(0, 1)) begin
          req.page_num = 7'($urandom_range(MAX_PAGES, 127));
        end else if (req.command == CMD_FAULT) begin
          req.proc_id = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(MAX_PROCS + 1, 31));
        end else begin
          req.proc_id = 5'($urandom_range(MAX_PROCS, 31));
        end
      end else if (pick < 28) begin
        req.command  = CMD_ALLOC;
        req.proc_id  = 5'($urandom_range(0, MAX_PROCS - 1));
        req.page_num = 7'($urandom_range(0, MAX_PAGES - 1));
      end else begin
        req.command  = CMD_FAULT;
        req.proc_id  = 5'($urandom_range(1, MAX_PROCS));
        req.page_num = 7'($urandom_range(0, MAX_PAGES - 1));
      end
      send_request(req, none);
    end
    in_valid <= 1'b0;

    while (pending_responses.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
